[design/wdpn_pkg.sv]
// ----------------------------------------------------------------------------
// wdpn_pkg
// shared types and constants of the white density peak node detector
// ----------------------------------------------------------------------------
package wdpn_pkg;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 11;
    localparam int CNT_W   = 4;
    localparam int POS_W   = 10;
    localparam int SCORE_W = 4;
    localparam int CLASS_W = 2;
    localparam int TDATA_W = 32;

    // bits of one window and of the emit mask in a queue record
    localparam int WIN_BITS  = 9 * CNT_W;
    localparam int EMIT_BITS = 4;

    // geometry limits below which the clamp holds
    localparam int MIN_DIM = 3;

    typedef logic [CNT_W-1:0] cnt_t;
    typedef cnt_t [2:0] cnt_row_t;
    typedef cnt_row_t [2:0] cnt_win_t;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_WHITE_LEVEL  = 2'd2
    } reg_index_t;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_NONE = 2'd0,
        CLASS_PEAK = 2'd1,
        CLASS_WEAK = 2'd2
    } node_class_t;

endpackage

[design/wdpn_ram.sv]
// ----------------------------------------------------------------------------
// wdpn_ram
// simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module wdpn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/wdpn_queue.sv]
// ----------------------------------------------------------------------------
// wdpn_queue
// short register fifo between the front and the back
// ----------------------------------------------------------------------------
module wdpn_queue #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic                       head_valid,
    output logic [WIDTH-1:0]           head,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (32'(p) == DEPTH - 1) ? '0 : PW'(32'(p) + 1);
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = CW'(32'(count_reg) + 32'(push) - 32'(pop));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

endmodule

[design/wdpn_front.sv]
// ----------------------------------------------------------------------------
// wdpn_front
// pixel intake: counters, line buffers, flag and count windows
// ----------------------------------------------------------------------------
module wdpn_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int QDEPTH     = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wdpn_pkg::PIX_W-1:0]        s_tdata,     // pixel_value
    input  logic [$clog2(MAX_WIDTH+1)-1:0]    w_eff,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]   h_eff,
    input  logic [wdpn_pkg::PIX_W-1:0]        white_level,
    input  logic [$clog2(QDEPTH+1)-1:0]       q_count,
    output logic                              q_push,
    output logic [wdpn_pkg::WIN_BITS + wdpn_pkg::EMIT_BITS
                  + $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT)-1:0] q_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH+1);
    localparam int HW = $clog2(MAX_HEIGHT+1);
    localparam int CN = wdpn_pkg::CNT_W;

    logic [AW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          b_valid_reg;
    logic          b_f_reg;
    logic [AW-1:0] b_cx_reg;
    logic [RW-1:0] b_cy_reg;
    logic [2:0][2:0]           fw_reg, fw_next;
    wdpn_pkg::cnt_win_t        cw_reg, cw_next;

    logic          accept;
    logic          col_wrap;
    logic [HW-1:0] row_inc;
    logic [AW-1:0] cx;
    logic [RW-1:0] cy;
    logic [WW-1:0] cx_inc;
    logic [HW-1:0] cy_inc;
    logic [1:0]    flag_rd;
    logic [2*CN-1:0] cnt_rd;
    wdpn_pkg::cnt_t  cnt;
    logic [wdpn_pkg::EMIT_BITS-1:0] emit;
    logic          on_last_col;
    logic          on_last_row;

    // items in flight must all fit in the queue
    assign s_tready = (32'(q_count) + 32'(b_valid_reg)) < QDEPTH;
    assign accept   = s_tvalid && s_tready;

    // geometry may have shrunk while idle
    always_comb begin
        col_wrap = (WW'(col_reg) >= w_eff);
        row_inc  = HW'(row_reg) + HW'(col_wrap);
        cx       = col_wrap ? '0 : col_reg;
        cy       = (row_inc >= h_eff) ? '0 : RW'(row_inc);
        cx_inc   = WW'(cx) + WW'(1);
        cy_inc   = HW'(cy) + HW'(1);
        if (cx_inc >= w_eff) begin
            col_next = '0;
            row_next = (cy_inc >= h_eff) ? '0 : RW'(cy_inc);
        end else begin
            col_next = AW'(cx_inc);
            row_next = cy;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= accept;
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_f_reg  <= (s_tdata == white_level);
            b_cx_reg <= cx;
            b_cy_reg <= cy;
        end
    end

    // flag lines: bit 0 two rows up, bit 1 one row up
    wdpn_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH)) u_flag_ram (
        .aclk  (aclk),
        .we    (b_valid_reg),
        .waddr (b_cx_reg),
        .wdata ({b_f_reg, flag_rd[1]}),
        .re    (accept),
        .raddr (cx),
        .rdata (flag_rd)
    );

    wdpn_ram #(.WIDTH(2*CN), .DEPTH(MAX_WIDTH)) u_cnt_ram (
        .aclk  (aclk),
        .we    (b_valid_reg),
        .waddr (b_cx_reg),
        .wdata ({cnt, cnt_rd[2*CN-1:CN]}),
        .re    (accept),
        .raddr (cx),
        .rdata (cnt_rd)
    );

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            fw_next[r][0] = fw_reg[r][1];
            fw_next[r][1] = fw_reg[r][2];
            cw_next[r][0] = cw_reg[r][1];
            cw_next[r][1] = cw_reg[r][2];
        end
        fw_next[0][2] = flag_rd[0];
        fw_next[1][2] = flag_rd[1];
        fw_next[2][2] = b_f_reg;

        cnt = '0;
        if (32'(b_cx_reg) >= 2 && 32'(b_cy_reg) >= 2) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    cnt = cnt + CN'(fw_next[r][c]);
                end
            end
        end

        cw_next[0][2] = cnt_rd[CN-1:0];
        cw_next[1][2] = cnt_rd[2*CN-1:CN];
        cw_next[2][2] = cnt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= '0;
            cw_reg <= '0;
        end else if (b_valid_reg) begin
            fw_reg <= fw_next;
            cw_reg <= cw_next;
        end
    end

    // emit mask: bit 0 centre (1,1), bit 1 (1,2), bit 2 (2,1), bit 3 (2,2)
    always_comb begin
        on_last_col = (WW'(b_cx_reg) == w_eff - WW'(1));
        on_last_row = (HW'(b_cy_reg) == h_eff - HW'(1));
        emit[0] = (32'(b_cy_reg) >= 3) && (32'(b_cx_reg) >= 3);
        emit[1] = (32'(b_cy_reg) >= 3) && on_last_col;
        emit[2] = on_last_row && (32'(b_cx_reg) >= 3);
        emit[3] = on_last_row && on_last_col;
    end

    assign q_push = b_valid_reg && (emit != '0);
    assign q_data = {b_cy_reg, b_cx_reg, emit, cw_next};

endmodule

[design/wdpn_back.sv]
// ----------------------------------------------------------------------------
// wdpn_back
// scores queued windows; one result item per cycle while m_tready is high
// ----------------------------------------------------------------------------
module wdpn_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    input  logic [wdpn_pkg::WIN_BITS + wdpn_pkg::EMIT_BITS
                  + $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT)-1:0] q_head,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wdpn_pkg::TDATA_W-1:0]        m_tdata,
    output logic                                m_tlast
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WB = wdpn_pkg::WIN_BITS;
    localparam int EB = wdpn_pkg::EMIT_BITS;
    localparam int PW = wdpn_pkg::POS_W;
    localparam int SW = wdpn_pkg::SCORE_W;

    wdpn_pkg::cnt_win_t win;
    logic [EB-1:0] emit, pend, sel_bit;
    logic [EB-1:0] done_reg, done_next;
    logic [1:0]    sel;
    logic          last_one;
    logic          load;
    logic [AW-1:0] cx, px;
    logic [RW-1:0] cy, py;
    logic [SW-1:0] score;
    logic          blank;
    wdpn_pkg::node_class_t cls;

    logic          tvalid_reg;
    logic [PW-1:0] pos_x_reg, pos_y_reg;
    logic          blank_reg, last_reg;
    logic [SW-1:0] score_reg;
    wdpn_pkg::node_class_t cls_reg;

    function automatic logic [SW-1:0] score_of(input wdpn_pkg::cnt_win_t w,
                                               input int r, input int c);
        logic [SW-1:0] s;
        int rr, cc;
        s = '0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                rr = r + dr;
                cc = c + dc;
                if ((dr != 0 || dc != 0) && rr <= 2 && cc <= 2) begin
                    if (w[rr][cc] >= w[r][c]) begin
                        s = s + SW'(1);
                    end
                end
            end
        end
        score_of = s;
    endfunction

    assign win  = wdpn_pkg::cnt_win_t'(q_head[WB-1:0]);
    assign emit = q_head[WB +: EB];
    assign cx   = q_head[WB+EB +: AW];
    assign cy   = q_head[WB+EB+AW +: RW];
    assign pend = emit & ~done_reg;

    always_comb begin
        priority if (pend[0]) sel = 2'd0;
        else if (pend[1])     sel = 2'd1;
        else if (pend[2])     sel = 2'd2;
        else                  sel = 2'd3;
        sel_bit  = EB'(1) << sel;
        last_one = ((pend & ~sel_bit) == '0);
        load     = q_valid && (!tvalid_reg || m_tready);
        q_pop    = load && last_one;
        done_next = done_reg;
        if (load) begin
            done_next = last_one ? '0 : (done_reg | sel_bit);
        end
    end

    // right column and bottom row centres sit one step closer to the newest pixel
    always_comb begin
        px    = cx - (sel[0] ? AW'(1) : AW'(2));
        py    = cy - (sel[1] ? RW'(1) : RW'(2));
        blank = (win[sel[1] ? 2 : 1][sel[0] ? 2 : 1] == '0);
        score = blank ? '0 : score_of(win, sel[1] ? 2 : 1, sel[0] ? 2 : 1);
        if (blank) begin
            cls = wdpn_pkg::CLASS_NONE;
        end else if (score == '0) begin
            cls = wdpn_pkg::CLASS_PEAK;
        end else if (score <= SW'(2)) begin
            cls = wdpn_pkg::CLASS_WEAK;
        end else begin
            cls = wdpn_pkg::CLASS_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvalid_reg <= 1'b0;
            done_reg   <= '0;
        end else begin
            done_reg <= done_next;
            if (load) begin
                tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pos_x_reg <= PW'(px);
            pos_y_reg <= PW'(py);
            blank_reg <= blank;
            score_reg <= score;
            cls_reg   <= cls;
            last_reg  <= (sel == 2'd3);
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = wdpn_pkg::TDATA_W'({cls_reg, score_reg, blank_reg,
                                           pos_y_reg, pos_x_reg});

endmodule

[design/white_density_peak_nodes.sv]
// ----------------------------------------------------------------------------
// white_density_peak_nodes
// 3x3 white pixel density with local peak scoring over a raster stream
// ----------------------------------------------------------------------------
//
// channel  dir  handshake                 payload
// s_       in   s_tvalid / s_tready       s_tdata[7:0] pixel_value
// m_       out  m_tvalid / m_tready       m_tdata pos_x..node_class, m_tlast last
// cfg_     in   cfg_valid / cfg_ready     cfg_index, cfg_wdata
//
// one pixel item per cycle sustained while the queue has room; a pixel is
// registered in the line buffer read stage, then its window enters the
// queue in the next cycle; results leave at one per cycle from the output
// register while m_tready is high; the final pixel of a frame brings up to
// four, so back pressure reaches s_tready through the four entry queue
// synchronous active low reset; line buffers are not cleared and need none
// cfg_ready is always high; the host writes only while the block is idle
//
module white_density_peak_nodes #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // pixel_value[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // pos_x[9:0], pos_y[19:10], blank[20],
                                    // score[24:21], node_class[26:25], zero
    output logic        m_tlast,    // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_wdata
);

    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int WW     = $clog2(MAX_WIDTH+1);
    localparam int HW     = $clog2(MAX_HEIGHT+1);
    localparam int QDEPTH = 4;
    localparam int QCW    = $clog2(QDEPTH+1);
    localparam int RECW   = wdpn_pkg::WIN_BITS + wdpn_pkg::EMIT_BITS + AW + RW;

    // configuration registers
    logic [wdpn_pkg::CFG_W-1:0] frame_width_reg;
    logic [wdpn_pkg::CFG_W-1:0] frame_height_reg;
    logic [wdpn_pkg::PIX_W-1:0] white_level_reg;
    logic                       cfg_we;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    logic            q_push, q_pop, q_valid;
    logic [RECW-1:0] q_data, q_head;
    logic [QCW-1:0]  q_count;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= 11'd640;
            frame_height_reg <= 11'd480;
            white_level_reg  <= 8'd255;
        end else if (cfg_we) begin
            unique case (cfg_index)
                wdpn_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                wdpn_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                wdpn_pkg::REG_WHITE_LEVEL:  white_level_reg  <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // clamp geometry to 3 .. max
    always_comb begin
        if (32'(frame_width_reg) < wdpn_pkg::MIN_DIM) begin
            w_eff = WW'(wdpn_pkg::MIN_DIM);
        end else if (32'(frame_width_reg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(frame_width_reg);
        end
        if (32'(frame_height_reg) < wdpn_pkg::MIN_DIM) begin
            h_eff = HW'(wdpn_pkg::MIN_DIM);
        end else if (32'(frame_height_reg) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(frame_height_reg);
        end
    end

    // front: counters, line buffers and windows
    wdpn_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .QDEPTH     (QDEPTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .w_eff       (w_eff),
        .h_eff       (h_eff),
        .white_level (white_level_reg),
        .q_count     (q_count),
        .q_push      (q_push),
        .q_data      (q_data)
    );

    // window queue decouples pixel intake from result output
    wdpn_queue #(.WIDTH(RECW), .DEPTH(QDEPTH)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_data),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head),
        .count      (q_count)
    );

    // back: scoring and result register
    wdpn_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // queue never takes a window while full
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (32'(q_count) < QDEPTH))
        else $error("window queue overflow");

    // a pop only happens with a window waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from empty window queue");

    // a blank window carries zero score and no node
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[20]) |-> (m_tdata[26:21] == 6'd0))
        else $error("blank result with score or class");

    // a peak node has score zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[26:25] == 2'd1) |-> (m_tdata[24:21] == 4'd0))
        else $error("peak node with nonzero score");

endmodule
